### rtl/pipc_pkg.sv
// ----------------------------------------------------------------------------
// pipc_pkg: shared types and constants of the point-in-polygon counter
// Holds field widths, opcodes and the queue entry type used across modules.
// ----------------------------------------------------------------------------
package pipc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_WIDTH  = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = 7;
    localparam int DIFF_W       = COORD_WIDTH + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int TALLY_W      = 32;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_ADDR_W   = 1;
    localparam int QDEPTH       = 2;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_TEST   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RAY_END_X    = 1'd1;

    localparam logic [CNT_W-1:0]        VCOUNT_RESET = 7'd0;
    localparam logic [COORD_WIDTH-1:0]  RAY_END_RESET = 16'd10240;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    // Work handed from the front part to the back part.
    typedef struct packed {
        logic   is_clear;
        coord_t px;
        coord_t py;
    } job_t;

    // Sign of a signed product difference, coded as orientation.
    typedef enum logic [1:0] {
        OR_COL = 2'd0,
        OR_CW  = 2'd1,
        OR_CCW = 2'd2
    } orient_t;

endpackage

### rtl/pipc_ram.sv
// ----------------------------------------------------------------------------
// pipc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pipc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

### rtl/pipc_front.sv
// ----------------------------------------------------------------------------
// pipc_front: accepts items, writes vertices, queues tests and clears
// A two-entry queue decouples intake from the edge-walking back part.
// ----------------------------------------------------------------------------
module pipc_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [1:0]                   s_opcode,
    input  logic [pipc_pkg::IDX_W-1:0]   s_index,
    input  pipc_pkg::coord_t             s_x,
    input  pipc_pkg::coord_t             s_y,
    output logic                         vwr_en,
    output logic [pipc_pkg::IDX_W-1:0]   vwr_addr,
    output logic [2*pipc_pkg::COORD_WIDTH-1:0] vwr_data,
    output logic                         job_valid,
    input  logic                         job_ready,
    output pipc_pkg::job_t               job
);
    import pipc_pkg::*;

    job_t             q_reg [QDEPTH];
    logic             wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             acc, push, pop;

    // Vertex writes touch the table only; with the back part reading the
    // table while running, write-after-test ordering is kept by stalling
    // writes until the queue and back part are idle.
    logic back_idle;
    assign back_idle = (cnt_reg == 2'd0) && job_ready;

    always_comb begin
        s_tready = (cnt_reg != 2'(QDEPTH));
        if (s_opcode == OP_WRITE) begin
            s_tready = back_idle;
        end
    end

    assign acc      = s_tvalid && s_tready;
    assign push     = acc && (s_opcode == OP_TEST || s_opcode == OP_CLEAR);
    assign pop      = job_valid && job_ready;
    assign vwr_en   = acc && (s_opcode == OP_WRITE);
    assign vwr_addr = s_index;
    assign vwr_data = {s_y, s_x};

    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            q_reg[wp_reg] <= '{is_clear: (s_opcode == OP_CLEAR), px: s_x, py: s_y};
        end
    end
endmodule

### rtl/pipc_back.sv
// ----------------------------------------------------------------------------
// pipc_back: walks the polygon edges for one test point, keeps the tallies
// One vertex read per cycle; edge orientation work runs in a short pipeline.
// ----------------------------------------------------------------------------
module pipc_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [pipc_pkg::CNT_W-1:0]   vertex_count,
    input  pipc_pkg::coord_t             ray_end_x,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  pipc_pkg::job_t               job,
    output logic [pipc_pkg::IDX_W-1:0]   vrd_addr,
    input  logic [2*pipc_pkg::COORD_WIDTH-1:0] vrd_data,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic                         m_inside,
    output logic [pipc_pkg::TALLY_W-1:0] m_inside_total,
    output logic [pipc_pkg::TALLY_W-1:0] m_tested_total
);
    import pipc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIRST = 6'b000010,
        S_WALK  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_DONE  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic             rd_v_reg;
    logic             rd_last_reg;
    coord_t px_reg, py_reg;
    coord_t v0x_reg, v0y_reg, ax_reg, ay_reg;
    logic             have_a_reg;
    logic             hits_reg, dec_reg, dec_val_reg;
    logic             edge_v_reg;
    logic             inside_reg;
    logic [TALLY_W-1:0] in_tot_reg, te_tot_reg;
    logic [TALLY_W-1:0] res_in_reg, res_te_reg;
    logic             out_v_reg;

    // Stage 1 registers: products for four orientations plus the collinear
    // test of the point against the edge.
    logic signed [PROD_W-1:0] p1a_reg [5], p1b_reg [5];
    coord_t e_ax_reg, e_ay_reg, e_bx_reg, e_by_reg;
    logic   e_v_reg;

    logic [CNT_W-1:0] n_eff;
    assign n_eff = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vertex_count;

    coord_t vx, vy;
    assign vx = vrd_data[COORD_WIDTH-1:0];
    assign vy = vrd_data[2*COORD_WIDTH-1:COORD_WIDTH];

    // Edge endpoints fed into stage 1.
    logic   feed;
    coord_t fax, fay, fbx, fby;
    always_comb begin
        feed = 1'b0;
        fax = ax_reg; fay = ay_reg; fbx = vx; fby = vy;
        if (rd_v_reg && have_a_reg) begin
            feed = 1'b1;
        end else if (state_reg == S_DRAIN && have_a_reg) begin
            feed = 1'b1;
            fbx  = v0x_reg;
            fby  = v0y_reg;
        end
    end

    function automatic logic signed [DIFF_W-1:0] df(coord_t a, coord_t b);
        df = DIFF_W'(a) - DIFF_W'(b);
    endfunction

    // Orientation products: o(p,q,r) = (qy-py)*(rx-qx) - (qx-px)*(ry-qy)
    logic signed [PROD_W-1:0] m1a [5], m1b [5];
    coord_t fx;
    assign fx = ray_end_x;
    always_comb begin
        // o1 = orient(A,B,P)
        m1a[0] = PROD_W'(df(fby, fay)) * PROD_W'(df(px_reg, fbx));
        m1b[0] = PROD_W'(df(fbx, fax)) * PROD_W'(df(py_reg, fby));
        // o2 = orient(A,B,F)
        m1a[1] = PROD_W'(df(fby, fay)) * PROD_W'(df(fx, fbx));
        m1b[1] = PROD_W'(df(fbx, fax)) * PROD_W'(df(py_reg, fby));
        // o3 = orient(P,F,A)  (qy-py = 0)
        m1a[2] = '0;
        m1b[2] = PROD_W'(df(fx, px_reg)) * PROD_W'(df(fay, py_reg));
        // o4 = orient(P,F,B)
        m1a[3] = '0;
        m1b[3] = PROD_W'(df(fx, px_reg)) * PROD_W'(df(fby, py_reg));
        // orient(A,P,B)
        m1a[4] = PROD_W'(df(py_reg, fay)) * PROD_W'(df(fbx, px_reg));
        m1b[4] = PROD_W'(df(px_reg, fax)) * PROD_W'(df(fby, py_reg));
    end

    function automatic orient_t ori(logic signed [PROD_W-1:0] a,
                                    logic signed [PROD_W-1:0] b);
        logic signed [PROD_W:0] d;
        d = (PROD_W+1)'(a) - (PROD_W+1)'(b);
        if (d == '0) ori = OR_COL;
        else if (d[PROD_W]) ori = OR_CCW;
        else ori = OR_CW;
    endfunction

    function automatic logic onseg(coord_t pxv, coord_t pyv, coord_t qx, coord_t qy,
                                   coord_t rx, coord_t ry);
        onseg = ((qx <= pxv) || (qx <= rx)) && ((qx >= pxv) || (qx >= rx)) &&
                ((qy <= pyv) || (qy <= ry)) && ((qy >= pyv) || (qy >= ry));
    endfunction

    // Stage 2 decision for one edge.
    orient_t o1, o2, o3, o4, o5;
    logic    meet, coll, ons;
    always_comb begin
        o1 = ori(p1a_reg[0], p1b_reg[0]);
        o2 = ori(p1a_reg[1], p1b_reg[1]);
        o3 = ori(p1a_reg[2], p1b_reg[2]);
        o4 = ori(p1a_reg[3], p1b_reg[3]);
        o5 = ori(p1a_reg[4], p1b_reg[4]);
        meet = ((o1 != o2) && (o3 != o4)) ||
               (o1 == OR_COL && onseg(e_ax_reg, e_ay_reg, px_reg, py_reg, e_bx_reg, e_by_reg)) ||
               (o2 == OR_COL && onseg(e_ax_reg, e_ay_reg, ray_end_x, py_reg, e_bx_reg, e_by_reg)) ||
               (o3 == OR_COL && onseg(px_reg, py_reg, e_ax_reg, e_ay_reg, ray_end_x, py_reg)) ||
               (o4 == OR_COL && onseg(px_reg, py_reg, e_bx_reg, e_by_reg, ray_end_x, py_reg));
        coll = (o5 == OR_COL);
        ons  = onseg(e_ax_reg, e_ay_reg, px_reg, py_reg, e_bx_reg, e_by_reg);
    end

    assign vrd_addr  = rd_cnt_reg[IDX_W-1:0];
    assign job_ready = (state_reg == S_IDLE);
    assign m_tvalid       = out_v_reg;
    assign m_inside       = inside_reg;
    assign m_inside_total = res_in_reg;
    assign m_tested_total = res_te_reg;

    logic final_in;
    assign final_in = dec_reg ? dec_val_reg : hits_reg;

    // Tally values after the current test; the result keeps its own copy so a
    // later clear cannot disturb a result that is still waiting.
    logic               hit_now;
    logic [TALLY_W-1:0] te_inc, in_inc;
    assign hit_now = (n_reg >= CNT_W'(3)) && final_in;
    assign te_inc  = (te_tot_reg != '1) ? te_tot_reg + 1'b1 : te_tot_reg;
    assign in_inc  = (hit_now && in_tot_reg != '1) ? in_tot_reg + 1'b1 : in_tot_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (job_valid && !job.is_clear) begin
                    state_next = (n_eff < CNT_W'(3)) ? S_DONE : S_FIRST;
                end
            end
            S_FIRST: state_next = S_WALK;
            S_WALK:  if (rd_last_reg) state_next = S_DRAIN;
            S_DRAIN: state_next = S_DONE;
            S_DONE:  if (!e_v_reg && !edge_v_reg && !out_v_reg) state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            rd_v_reg   <= 1'b0;
            e_v_reg    <= 1'b0;
            edge_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            in_tot_reg <= '0;
            te_tot_reg <= '0;
        end else begin
            state_reg <= state_next;
            e_v_reg   <= feed;
            edge_v_reg <= 1'b0;
            if (out_v_reg && m_tready) out_v_reg <= 1'b0;
            rd_v_reg <= (state_reg == S_FIRST) || (state_reg == S_WALK && !rd_last_reg);
            if (job_valid && job_ready && job.is_clear) begin
                in_tot_reg <= '0;
                te_tot_reg <= '0;
            end
            if (state_reg == S_OUT) begin
                out_v_reg  <= 1'b1;
                inside_reg <= hit_now;
                te_tot_reg <= te_inc;
                in_tot_reg <= in_inc;
                res_te_reg <= te_inc;
                res_in_reg <= in_inc;
            end
        end
        if (state_reg == S_IDLE) begin
            px_reg     <= job.px;
            py_reg     <= job.py;
            n_reg      <= n_eff;
            rd_cnt_reg <= '0;
            have_a_reg <= 1'b0;
            hits_reg   <= 1'b0;
            dec_reg    <= 1'b0;
            dec_val_reg <= 1'b0;
        end
        if (state_reg == S_FIRST || (state_reg == S_WALK && !rd_last_reg)) begin
            rd_cnt_reg <= rd_cnt_reg + 1'b1;
        end
        rd_last_reg <= (state_reg == S_FIRST || state_reg == S_WALK) &&
                       (rd_cnt_reg + 1'b1 == n_reg);
        if (rd_v_reg) begin
            ax_reg <= vx;
            ay_reg <= vy;
            have_a_reg <= 1'b1;
            if (!have_a_reg) begin
                v0x_reg <= vx;
                v0y_reg <= vy;
            end
        end
        if (feed) begin
            for (int i = 0; i < 5; i++) begin
                p1a_reg[i] <= m1a[i];
                p1b_reg[i] <= m1b[i];
            end
            e_ax_reg <= fax; e_ay_reg <= fay;
            e_bx_reg <= fbx; e_by_reg <= fby;
        end
        if (e_v_reg && meet && !dec_reg) begin
            if (coll) begin
                dec_reg     <= 1'b1;
                dec_val_reg <= ons;
            end else begin
                hits_reg <= ~hits_reg;
            end
        end
    end
endmodule

### rtl/point_in_polygon_counter_core.sv
// ----------------------------------------------------------------------------
// point_in_polygon_counter_core: ray-casting point-in-polygon test with tallies
// Each test item walks the polygon edges through the single vertex-table read
// port, one edge per cycle; the walk is skipped when fewer than three vertices
// are in use. One test is worked on at a time. Writes and clears give no result.
// Synchronous active-low reset clears the tallies, control state and configuration
// registers; the vertex table is undefined until written.
// ----------------------------------------------------------------------------
module point_in_polygon_counter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: opcode[1:0], vertex_index[7:2], coord_x[23:8], coord_y[39:24]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: inside_res[0], inside_total[32:1], tested_total[64:33], zeros above
    output logic [71:0] m_tdata,
    input  logic        cfg_we,
    input  logic [pipc_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [pipc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pipc_pkg::*;

    logic [CNT_W-1:0] vcount_reg;
    coord_t           ray_x_reg;

    // Configuration registers; user writes only while idle (block does not check).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCOUNT_RESET;
            ray_x_reg  <= RAY_END_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_VERTEX_COUNT: vcount_reg <= cfg_data[CNT_W-1:0];
                REG_RAY_END_X:    ray_x_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic                   vwr_en;
    logic [IDX_W-1:0]       vwr_addr, vrd_addr;
    logic [2*COORD_WIDTH-1:0] vwr_data, vrd_data;
    logic                   job_valid, job_ready;
    job_t                   job;
    logic                   m_inside;
    logic [TALLY_W-1:0]     m_in_tot, m_te_tot;

    // Front part: intake, vertex writes and the job queue.
    pipc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_opcode  (s_tdata[1:0]),
        .s_index   (s_tdata[7:2]),
        .s_x       (s_tdata[23:8]),
        .s_y       (s_tdata[39:24]),
        .vwr_en    (vwr_en),
        .vwr_addr  (vwr_addr),
        .vwr_data  (vwr_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    // The vertex table: one write port for loads, one read port for the walk.
    pipc_ram #(.WIDTH(2*COORD_WIDTH), .DEPTH(MAX_VERTICES)) u_vtab (
        .aclk    (aclk),
        .wr_en   (vwr_en),
        .wr_addr (vwr_addr),
        .wr_data (vwr_data),
        .rd_addr (vrd_addr),
        .rd_data (vrd_data)
    );

    // Back part: edge walk, decision and the saturating tallies.
    pipc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .vertex_count   (vcount_reg),
        .ray_end_x      (ray_x_reg),
        .job_valid      (job_valid),
        .job_ready      (job_ready),
        .job            (job),
        .vrd_addr       (vrd_addr),
        .vrd_data       (vrd_data),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_inside       (m_inside),
        .m_inside_total (m_in_tot),
        .m_tested_total (m_te_tot)
    );

    assign m_tdata = {7'd0, m_te_tot, m_in_tot, m_inside};
endmodule
